### hdl/dgbd_pkg.sv
// Shared types and constants for the dual group button debouncer.
package dgbd_pkg;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_RELEASE_SELECT = 2'd0;
   localparam logic [1:0] CSR_PRESS_SELECT   = 2'd1;
   localparam logic [1:0] CSR_SETTLE_MS      = 2'd2;

   // Settle time after reset, in ms
   localparam logic [7:0] SETTLE_RESET = 8'd15;

   // One pin sample with its timestamp
   typedef struct packed {
      logic [15:0] pin_levels;
      logic [31:0] time_ms;
   } req_type;

   // One debounce report
   typedef struct packed {
      logic [15:0] released_pins;
      logic [15:0] pressed_pins;
      logic [31:0] held_ms;
   } rsp_type;

   // What one machine hands on for the current sample
   typedef struct packed {
      logic [31:0] dur;
      logic [15:0] report;
   } mach_out_type;

endpackage

### hdl/dgbd_machine.sv
// One four-phase debounce machine with its phase, start time and tracked pins.
module dgbd_machine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [15:0]             sel,
   input  logic [15:0]             seen,
   input  logic [15:0]             active,
   input  logic [31:0]             now_ms,
   input  logic [7:0]              settle_ms,
   input  logic [31:0]             dur_in,
   output dgbd_pkg::mach_out_type  result
);

   typedef enum logic [1:0] {
      IDLE       = 2'd0,
      SETTLE_ON  = 2'd1,
      HELD       = 2'd2,
      SETTLE_OFF = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] start_ff, start_in;
   logic [15:0] track_ff, track_in;
   logic [31:0] elapsed;
   logic        settled;

   // elapsed time wraps mod 2^32
   assign elapsed = now_ms - start_ff;
   assign settled = (elapsed >= {24'd0, settle_ms});

   // next state and the duration handed on to the next machine
   always_comb begin
      phase_in      = phase_ff;
      start_in      = start_ff;
      track_in      = track_ff;
      result.dur    = dur_in;
      result.report = '0;
      case (phase_ff)
         IDLE: begin
            if (|(active & sel)) begin
               track_in = active & sel;
               start_in = now_ms;
               phase_in = SETTLE_ON;
            end
         end
         SETTLE_ON: begin
            if (settled) begin
               if (|(active & track_ff)) begin
                  result.dur = start_ff;
                  track_in   = active & track_ff;
                  phase_in   = HELD;
               end else begin
                  phase_in = IDLE;
               end
            end
         end
         HELD: begin
            if (|(seen & track_ff)) begin
               track_in = seen & track_ff;
               start_in = now_ms;
               phase_in = SETTLE_OFF;
            end else if (track_ff != (active & sel)) begin
               phase_in = IDLE;
            end
         end
         SETTLE_OFF: begin
            if (settled) begin
               if (|(seen & track_ff)) begin
                  result.dur    = now_ms - dur_in;
                  result.report = seen & track_ff;
                  phase_in      = IDLE;
               end else begin
                  phase_in = HELD;
               end
            end
         end
         default: begin
            phase_in = IDLE;
         end
      endcase
   end

   // state update, once per word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= IDLE;
         start_ff <= '0;
         track_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         track_ff <= track_in;
      end
   end

endmodule

### hdl/dual_group_button_debouncer.sv
// Top level: input register, release and press machines, result register.
//
//   port group   dir   handshake            payload
//   req_*        in    req_valid/req_stall  dgbd_pkg::req_type
//   rsp_*        out   rsp_valid/rsp_stall  dgbd_pkg::rsp_type
//   csr_*        in    csr_write            csr_index, csr_data
//
// One word per clock unless the result stalls. Both machines and the
// shared duration register update in the single cycle in which a word
// moves from the input register to the result register. Reset idles
// both machines and loads the register defaults. A stalled result holds
// the input register; one more word can wait there.
module dual_group_button_debouncer #(
   parameter int PIN_COUNT = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dgbd_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dgbd_pkg::rsp_type rsp_word,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);

   localparam logic [15:0] PinMask = 16'((33'd1 << PIN_COUNT) - 33'd1);

   logic                   in_valid_ff;
   dgbd_pkg::req_type      in_word_ff;
   logic                   rsp_valid_ff;
   dgbd_pkg::rsp_type      rsp_word_ff, rsp_word_in;
   logic [31:0]            dur_ff;
   logic [15:0]            release_sel_ff;
   logic [15:0]            press_sel_ff;
   logic [7:0]             settle_ff;
   logic                   advance;
   logic [15:0]            levels;
   logic [15:0]            levels_n;
   dgbd_pkg::mach_out_type rel_out;
   dgbd_pkg::mach_out_type prs_out;

   // word moves on when the result register is free or draining
   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         release_sel_ff <= '0;
         press_sel_ff   <= '0;
         settle_ff      <= dgbd_pkg::SETTLE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            dgbd_pkg::CSR_RELEASE_SELECT: release_sel_ff <= csr_data;
            dgbd_pkg::CSR_PRESS_SELECT:   press_sel_ff   <= csr_data;
            dgbd_pkg::CSR_SETTLE_MS:      settle_ff      <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
   end

   // pins at PIN_COUNT and above read as neither high nor low
   assign levels   = in_word_ff.pin_levels & PinMask;
   assign levels_n = ~in_word_ff.pin_levels & PinMask;

   // release machine sees raw levels and writes the duration first
   dgbd_machine u_release (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .sel       (release_sel_ff & PinMask),
      .seen      (levels),
      .active    (levels_n),
      .now_ms    (in_word_ff.time_ms),
      .settle_ms (settle_ff),
      .dur_in    (dur_ff),
      .result    (rel_out)
   );

   // press machine sees inverted levels and the release machine's duration
   dgbd_machine u_press (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .sel       (press_sel_ff & PinMask),
      .seen      (levels_n),
      .active    (levels),
      .now_ms    (in_word_ff.time_ms),
      .settle_ms (settle_ff),
      .dur_in    (rel_out.dur),
      .result    (prs_out)
   );

   // result word
   always_comb begin
      rsp_word_in.released_pins = rel_out.report;
      rsp_word_in.pressed_pins  = prs_out.report;
      rsp_word_in.held_ms       = (|(rel_out.report | prs_out.report)) ? prs_out.dur : '0;
   end

   // shared duration register, written before it is ever read
   always_ff @(posedge clock) begin
      if (advance) begin
         dur_ff <= prs_out.dur;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

### hdl/dgbd_checker.sv
// Port-level checks for the dual group button debouncer, bound to the top.
module dgbd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dgbd_pkg::rsp_type rsp_word
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed under stall");

   // a duration only goes out with a report
   a_held_with_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.held_ms == 32'd0) || (rsp_word.released_pins != 16'd0) ||
                    (rsp_word.pressed_pins != 16'd0))
      else $error("held time without a report");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a taken word passes the input register and reaches the output when the result is not stalled
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted word did not reach the output");

endmodule

bind dual_group_button_debouncer dgbd_checker u_dgbd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
